// ===== sv/time_of_day_relative_volume_core_defines.svh =====
// assertion macros for the relative volume core
// needs clk and arst_n in the scope of the module that uses them
`ifndef TIME_OF_DAY_RELATIVE_VOLUME_CORE_DEFINES_SVH
`define TIME_OF_DAY_RELATIVE_VOLUME_CORE_DEFINES_SVH

// same-cycle implication, reset masked
`define TODRV_AST_IMPL(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, reset masked
`define TODRV_AST_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/todrv_pkg.sv =====
// shared constants, controller states and command/status types
// no dependencies
package todrv_pkg;

	localparam int unsigned TIME_SLOTS_DEF   = 256;
	localparam int unsigned MAX_LOOKBACK_DEF = 64;

	localparam int unsigned SLOT_W = 8;
	localparam int unsigned VOL_W  = 32;
	localparam int unsigned LB_W   = 7;
	localparam int unsigned RV_W   = 32;

	// quotient bits resolved by the divider, one per step
	localparam int unsigned QUO_W       = 33;
	localparam int unsigned DCNT_W      = 6;
	// 25600 = 25 << 10
	localparam int unsigned SCALE_SHIFT = 10;
	localparam int unsigned HI_SHIFT    = QUO_W - SCALE_SHIFT;

	localparam int unsigned        LB_MIN     = 5;
	localparam logic [LB_W-1:0]    LB_RESET   = 7'd5;
	localparam logic [QUO_W-1:0]   SAT_THRESH = 33'd2147509247;
	localparam logic [RV_W-1:0]    RV_SAT     = 32'h7FFF_FFFF;
	localparam logic [RV_W-1:0]    RV_OFFSET  = 32'd25600;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SLOT_RD,
		ST_SLOT_CAP,
		ST_CHECK,
		ST_SWEEP,
		ST_SWEEP_END,
		ST_OLD_RD,
		ST_OLD_CAP,
		ST_COMMIT,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic clr_wr;
		logic accept;
		logic slot_rd;
		logic slot_cap;
		logic sweep_rd;
		logic old_rd;
		logic old_cap;
		logic commit;
		logic div_step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic sum_ok;
		logic sweep_last;
		logic ready;
		logic sum_zero;
		logic div_last;
		logic out_free;
	} status_t;

endpackage

// ===== sv/time_of_day_relative_volume_core.sv =====
// Relative volume by time of day. Each input beat is one finished bar (time_slot, volume);
// each bar gives exactly one output beat with ready_res, zero_average and
// relative_volume_q8 = floor(25600*volume*lookback/sum) - 25600, signed Q8, saturated at
// the top, where sum is the total of the newest lookback earlier volumes of the same slot.
// The volume is stored after the comparison. One bar is processed at a time: a bar that
// is ready with a nonzero window goes through the 33-step restoring divider (one quotient
// bit per cycle); a bar that is not ready or has a zero window skips it. Each slot keeps
// a running window sum tagged with the lookback it was formed with; after lookback is
// rewritten, or on a slot's first bar, the sum is rebuilt from the history ram at one
// entry per cycle. The history ram holds TIME_SLOTS*MAX_LOOKBACK words of 32 bits. After
// reset a clearing pass zeroes every entry of the slot state ram; in_stall stays high
// during it. A finished result sits in an output register, so the next bar is taken
// while the previous result waits. The user must write lookback only while the block is
// idle; the block itself does not enforce it.
`include "time_of_day_relative_volume_core_defines.svh"

module time_of_day_relative_volume_core
	import todrv_pkg::*;
#(
	parameter int unsigned TIME_SLOTS   = TIME_SLOTS_DEF,
	parameter int unsigned MAX_LOOKBACK = MAX_LOOKBACK_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,

	// lookback register write
	input  logic                   lookback_we,
	input  logic [LB_W-1:0]        lookback_wdata,

	// bar input
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [SLOT_W-1:0]      time_slot,
	input  logic [VOL_W-1:0]       volume,

	// result output
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic                   ready_res,
	output logic                   zero_average,
	output logic signed [RV_W-1:0] relative_volume_q8
);

	cmd_t    cmd;
	status_t sts;

	// controller: clearing pass, slot read, window rebuild, divider sequencing
	todrv_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath: rams, window sum update, divider, output register
	todrv_dpath #(
		.TIME_SLOTS   (TIME_SLOTS),
		.MAX_LOOKBACK (MAX_LOOKBACK)
	) u_dpath (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.sts                (sts),
		.lookback_we        (lookback_we),
		.lookback_wdata     (lookback_wdata),
		.time_slot          (time_slot),
		.volume             (volume),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.ready_res          (ready_res),
		.zero_average       (zero_average),
		.relative_volume_q8 (relative_volume_q8)
	);

	// one bar at a time: busy right after a beat is taken
	`TODRV_AST_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "accepted twice in a row")
	// a loaded result shows up as an output beat
	`TODRV_AST_NEXT(a_load_shows_beat, cmd.out_load, out_valid, "loaded result not presented")
	// zero window only on a ready bar, value forced to zero
	`TODRV_AST_IMPL(a_zero_is_ready, out_valid && zero_average, ready_res && relative_volume_q8 == '0, "zero average flag inconsistent")
	// bars without history report nothing
	`TODRV_AST_IMPL(a_not_ready_quiet, out_valid && !ready_res, !zero_average && relative_volume_q8 == '0, "not ready result nonzero")

endmodule

// ===== sv/todrv_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module todrv_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 64,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== sv/todrv_ctrl.sv =====
// sequencing state machine for the relative volume core
// depends on todrv_pkg
module todrv_ctrl
	import todrv_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	input  status_t sts,
	output cmd_t    cmd
);

	state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (sts.clr_last) state_nxt = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) state_nxt = ST_SLOT_RD;
			end
			ST_SLOT_RD:   state_nxt = ST_SLOT_CAP;
			ST_SLOT_CAP:  state_nxt = ST_CHECK;
			ST_CHECK: begin
				state_nxt = sts.sum_ok ? ST_OLD_RD : ST_SWEEP;
			end
			ST_SWEEP: begin
				if (sts.sweep_last) state_nxt = ST_SWEEP_END;
			end
			ST_SWEEP_END: state_nxt = ST_OLD_RD;
			ST_OLD_RD:    state_nxt = ST_OLD_CAP;
			ST_OLD_CAP:   state_nxt = ST_COMMIT;
			ST_COMMIT: begin
				state_nxt = (sts.ready && !sts.sum_zero) ? ST_DIV : ST_DONE;
			end
			ST_DIV: begin
				if (sts.div_last) state_nxt = ST_DONE;
			end
			ST_DONE: begin
				if (sts.out_free) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_CLEAR:    cmd.clr_wr = 1'b1;
			ST_IDLE: begin
				in_stall   = 1'b0;
				cmd.accept = in_valid;
			end
			ST_SLOT_RD:  cmd.slot_rd  = 1'b1;
			ST_SLOT_CAP: cmd.slot_cap = 1'b1;
			ST_SWEEP:    cmd.sweep_rd = 1'b1;
			ST_OLD_RD:   cmd.old_rd   = 1'b1;
			ST_OLD_CAP:  cmd.old_cap  = 1'b1;
			ST_COMMIT:   cmd.commit   = 1'b1;
			ST_DIV:      cmd.div_step = 1'b1;
			ST_DONE:     cmd.out_load = sts.out_free;
			default: begin
				cmd      = '0;
				in_stall = 1'b1;
			end
		endcase
	end

endmodule

// ===== sv/todrv_dpath.sv =====
// datapath: slot state and history rams, window sum, serial divider, result register
// depends on todrv_pkg and todrv_ram
module todrv_dpath
	import todrv_pkg::*;
#(
	parameter int unsigned TIME_SLOTS   = TIME_SLOTS_DEF,
	parameter int unsigned MAX_LOOKBACK = MAX_LOOKBACK_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cmd_t                    cmd,
	output status_t                 sts,
	input  logic                    lookback_we,
	input  logic [LB_W-1:0]         lookback_wdata,
	input  logic [SLOT_W-1:0]       time_slot,
	input  logic [VOL_W-1:0]        volume,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic                    ready_res,
	output logic                    zero_average,
	output logic signed [RV_W-1:0]  relative_volume_q8
);

	localparam int unsigned LW     = $clog2(MAX_LOOKBACK + 1);
	localparam int unsigned PTRW   = $clog2(MAX_LOOKBACK);
	localparam int unsigned SUMW   = VOL_W + LW;
	localparam int unsigned SW     = (TIME_SLOTS > 1) ? $clog2(TIME_SLOTS) : 1;
	localparam int unsigned HDEPTH = TIME_SLOTS * MAX_LOOKBACK;
	localparam int unsigned HAW    = $clog2(HDEPTH);
	localparam int unsigned PRODW  = VOL_W + LW;
	localparam int unsigned PW     = PRODW + 5;
	localparam int unsigned HIW    = PW - HI_SHIFT;
	localparam int unsigned SWORD  = LW + LW + PTRW + SUMW;
	localparam int unsigned CW     = (LW > LB_W) ? LW : LB_W;
	localparam int unsigned DW     = LW + 1;

	// slot number reduced to the slot count, one remainder bit per step
	function automatic logic [SW-1:0] slot_mod(input logic [SLOT_W-1:0] raw);
		logic [SW:0] r;
		r = '0;
		for (int i = SLOT_W - 1; i >= 0; i--) begin
			r = {r[SW-1:0], raw[i]};
			if (r >= (SW+1)'(TIME_SLOTS)) r = r - (SW+1)'(TIME_SLOTS);
		end
		return r[SW-1:0];
	endfunction

	logic [LB_W-1:0]  lookback_q;
	logic [LW-1:0]    eff_lb;
	logic [CW-1:0]    lb_ext;

	logic [SW-1:0]    slot_q;
	logic [VOL_W-1:0] vol_q;
	logic [PRODW-1:0] prod_q;
	logic [PW-1:0]    num_q;
	logic [LW-1:0]    fill_q;
	logic [PTRW-1:0]  ptr_q;
	logic [LW-1:0]    tag_q;
	logic [SUMW-1:0]  sum_q;
	logic [LW-1:0]    cnt_q;
	logic [PTRW-1:0]  rp_q;
	logic             pend_q;
	logic [VOL_W-1:0] old_q;
	logic [SUMW-1:0]  rem_q;
	logic [QUO_W-1:0] nbits_q;
	logic [QUO_W-1:0] quo_q;
	logic             sat_q;
	logic [DCNT_W-1:0] dcnt_q;
	logic [SW-1:0]    clr_q;

	logic             out_valid_q;
	logic             ready_res_q;
	logic             zero_avg_q;
	logic [RV_W-1:0]  rv_q;

	// slot state ram word: lookback tag, fill count, write pointer, window sum
	logic             sram_we;
	logic [SW-1:0]    sram_waddr;
	logic [SWORD-1:0] sram_wdata;
	logic [SWORD-1:0] sram_rdata;
	logic [LW-1:0]    s_tag;
	logic [LW-1:0]    s_fill;
	logic [PTRW-1:0]  s_ptr;
	logic [SUMW-1:0]  s_sum;

	logic             hram_we;
	logic             hram_re;
	logic [HAW-1:0]   hram_waddr;
	logic [HAW-1:0]   hram_raddr;
	logic [VOL_W-1:0] hram_rdata;

	logic [HAW-1:0]   base;
	logic [PTRW-1:0]  rp_nxt;
	logic [PTRW-1:0]  old_idx;
	logic [DW-1:0]    old_tmp;
	logic             sweep_issue;
	logic             ready;
	logic [LW-1:0]    fill_nxt;
	logic [PTRW-1:0]  ptr_nxt;
	logic [SUMW:0]    sum_tmp;
	logic [SUMW-1:0]  sum_nxt;
	logic [HIW-1:0]   num_hi;
	logic [SUMW:0]    rem_sh;
	logic             quo_bit;
	logic             out_free;
	logic             res_zero;
	logic [RV_W-1:0]  res_val;

	// lookback register and its clamped value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lookback_q <= LB_RESET;
		end else if (lookback_we) begin
			lookback_q <= lookback_wdata;
		end
	end

	assign lb_ext = CW'(lookback_q);

	always_comb begin
		if (lb_ext < CW'(LB_MIN)) begin
			eff_lb = LW'(LB_MIN);
		end else if (lb_ext > CW'(MAX_LOOKBACK)) begin
			eff_lb = LW'(MAX_LOOKBACK);
		end else begin
			eff_lb = LW'(lb_ext);
		end
	end

	assign {s_tag, s_fill, s_ptr, s_sum} = sram_rdata;

	assign base = HAW'(HAW'(slot_q) * HAW'(MAX_LOOKBACK));

	assign rp_nxt = (rp_q == '0) ? PTRW'(MAX_LOOKBACK - 1) : rp_q - 1'b1;

	// oldest entry of the window, pointer minus lookback around the ring
	always_comb begin
		if (DW'(ptr_q) >= DW'(eff_lb)) begin
			old_tmp = DW'(ptr_q) - DW'(eff_lb);
		end else begin
			old_tmp = DW'(ptr_q) + DW'(MAX_LOOKBACK) - DW'(eff_lb);
		end
		old_idx = old_tmp[PTRW-1:0];
	end

	assign sweep_issue = cmd.sweep_rd && (cnt_q != '0);
	assign ready       = (fill_q >= eff_lb);

	assign fill_nxt = (fill_q == LW'(MAX_LOOKBACK)) ? fill_q : fill_q + 1'b1;
	assign ptr_nxt  = (ptr_q == PTRW'(MAX_LOOKBACK - 1)) ? '0 : ptr_q + 1'b1;
	assign sum_tmp  = {1'b0, sum_q} + (SUMW+1)'(vol_q)
	                - (ready ? (SUMW+1)'(old_q) : '0);
	assign sum_nxt  = sum_tmp[SUMW-1:0];

	assign num_hi  = num_q[PW-1:HI_SHIFT];
	assign rem_sh  = {rem_q, nbits_q[QUO_W-1]};
	assign quo_bit = (rem_sh >= {1'b0, sum_q});

	// ram port muxing
	assign sram_we    = cmd.clr_wr || cmd.commit;
	assign sram_waddr = cmd.clr_wr ? clr_q : slot_q;
	assign sram_wdata = cmd.clr_wr ? '0 : {eff_lb, fill_nxt, ptr_nxt, sum_nxt};

	assign hram_we    = cmd.commit;
	assign hram_waddr = base + HAW'(ptr_q);
	assign hram_re    = sweep_issue || cmd.old_rd;
	assign hram_raddr = base + HAW'(cmd.old_rd ? old_idx : rp_nxt);

	todrv_ram #(
		.WIDTH (SWORD),
		.DEPTH (TIME_SLOTS)
	) u_slot_ram (
		.clk   (clk),
		.we    (sram_we),
		.waddr (sram_waddr),
		.wdata (sram_wdata),
		.re    (cmd.slot_rd),
		.raddr (slot_q),
		.rdata (sram_rdata)
	);

	todrv_ram #(
		.WIDTH (VOL_W),
		.DEPTH (HDEPTH)
	) u_hist_ram (
		.clk   (clk),
		.we    (hram_we),
		.waddr (hram_waddr),
		.wdata (vol_q),
		.re    (hram_re),
		.raddr (hram_raddr),
		.rdata (hram_rdata)
	);

	// control counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			cnt_q  <= '0;
			pend_q <= 1'b0;
			dcnt_q <= '0;
		end else begin
			if (cmd.clr_wr) clr_q <= clr_q + 1'b1;
			if (cmd.slot_cap) begin
				cnt_q <= (s_fill < eff_lb) ? s_fill : eff_lb;
			end else if (sweep_issue) begin
				cnt_q <= cnt_q - 1'b1;
			end
			pend_q <= sweep_issue;
			if (cmd.commit) begin
				dcnt_q <= DCNT_W'(QUO_W);
			end else if (cmd.div_step) begin
				dcnt_q <= dcnt_q - 1'b1;
			end
		end
	end

	// item payload and working registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			slot_q <= slot_mod(time_slot);
			vol_q  <= volume;
		end
		if (cmd.slot_rd) begin
			prod_q <= PRODW'(vol_q) * PRODW'(eff_lb);
		end
		if (cmd.slot_cap) begin
			fill_q <= s_fill;
			ptr_q  <= s_ptr;
			rp_q   <= s_ptr;
			tag_q  <= s_tag;
			sum_q  <= (s_tag == eff_lb) ? s_sum : '0;
			num_q  <= (PW'(prod_q) << 4) + (PW'(prod_q) << 3) + PW'(prod_q);
		end else if (pend_q) begin
			sum_q <= sum_q + SUMW'(hram_rdata);
		end
		if (sweep_issue) rp_q <= rp_nxt;
		if (cmd.old_cap) old_q <= hram_rdata;
		if (cmd.commit) begin
			rem_q   <= SUMW'(num_hi);
			sat_q   <= (SUMW'(num_hi) >= sum_q);
			nbits_q <= {num_q[HI_SHIFT-1:0], {SCALE_SHIFT{1'b0}}};
			quo_q   <= '0;
		end else if (cmd.div_step) begin
			rem_q   <= quo_bit ? SUMW'(rem_sh - {1'b0, sum_q}) : rem_sh[SUMW-1:0];
			nbits_q <= nbits_q << 1;
			quo_q   <= {quo_q[QUO_W-2:0], quo_bit};
		end
	end

	// result formatting
	assign res_zero = ready && (sum_q == '0);

	always_comb begin
		if (!ready || res_zero) begin
			res_val = '0;
		end else if (sat_q || (quo_q >= SAT_THRESH)) begin
			res_val = RV_SAT;
		end else begin
			res_val = quo_q[RV_W-1:0] - RV_OFFSET;
		end
	end

	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			ready_res_q <= ready;
			zero_avg_q  <= res_zero;
			rv_q        <= res_val;
		end
	end

	assign out_valid          = out_valid_q;
	assign ready_res          = ready_res_q;
	assign zero_average       = zero_avg_q;
	assign relative_volume_q8 = rv_q;

	assign sts.clr_last   = (clr_q == SW'(TIME_SLOTS - 1));
	assign sts.sum_ok     = (tag_q == eff_lb);
	assign sts.sweep_last = (cnt_q <= LW'(1));
	assign sts.ready      = ready;
	assign sts.sum_zero   = (sum_q == '0);
	assign sts.div_last   = (dcnt_q == DCNT_W'(1));
	assign sts.out_free   = out_free;

endmodule
